### hw/rtl/kps_pkg.sv
`default_nettype none
package kps_pkg;

    localparam int MAX_KEYS_DEF = 64;

    // action codes of an input transaction
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [15:0] ONE_Q14 = 16'h4000;
    localparam int          CORDIC_STEPS = 20;
    localparam logic [33:0] NEAR_LIMIT = 34'd268419072;
    localparam logic [35:0] CORDIC_KINV = 36'd652032874;

    // shared divider widths
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 32;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        time_req;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } t_in;

    typedef struct packed {
        logic [31:0]        time_req;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } t_key;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_rot_w;
        logic signed [15:0] out_rot_x;
        logic signed [15:0] out_rot_y;
        logic signed [15:0] out_rot_z;
        logic signed [31:0] out_scale_x;
        logic signed [31:0] out_scale_y;
        logic signed [31:0] out_scale_z;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    // arctangent of 2^-i, Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // linear fields: position x,y,z then scale x,y,z
    function automatic logic signed [31:0] key_lin(input t_key k, input logic [2:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            3'd0: v = k.pos_x;
            3'd1: v = k.pos_y;
            3'd2: v = k.pos_z;
            3'd3: v = k.scale_x;
            3'd4: v = k.scale_y;
            3'd5: v = k.scale_z;
            default: v = '0;
        endcase
        return v;
    endfunction

    // quaternion components w,x,y,z
    function automatic logic signed [15:0] key_rot(input t_key k, input logic [1:0] idx);
        logic signed [15:0] v;
        unique case (idx)
            2'd0: v = k.rot_w;
            2'd1: v = k.rot_x;
            2'd2: v = k.rot_y;
            2'd3: v = k.rot_z;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/kps_ram.sv
`default_nettype none
module kps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/kps_div.sv
`default_nettype none
module kps_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kps_pkg::t_div_req i_req,
    output kps_pkg::t_div_rsp      o_rsp
);

    localparam int NW = kps_pkg::DIV_NW;
    localparam int DW = kps_pkg::DIV_DW;
    localparam int CNTW = $clog2(NW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_den;
    logic [DW:0]     w_rem2;
    logic [DW:0]     w_sub;
    logic            w_ge;

    // one restoring step: shift in the next numerator bit
    assign w_rem2 = {r_rem, r_quo[NW-1]};
    assign w_sub  = w_rem2 - {1'b0, r_den};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DW-1:0] : w_rem2[DW-1:0];
                r_quo <= {r_quo[NW-2:0], w_ge};
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

### hw/rtl/keyframe_pose_sampler_top.sv
`default_nettype none
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_data  (kps_pkg::t_in)
// result    out        o_out_valid / i_out_stall  o_out_data (kps_pkg::t_out)
//
// A sample of a non-empty table runs the time scan; past the last key it returns that
// key, else the factor division on the shared divider and six blends follow, then the
// rotation blends for a nearly parallel rotation or a slerp (29-step square root, three
// 20-step CORDIC runs, four divisions on the shared divider). Synchronous active-low
// reset empties the table; no clearing pass. A stalled result stays in the output
// register while clears and appends are still taken.
module keyframe_pose_sampler_top #(
    parameter int MAX_KEYS = kps_pkg::MAX_KEYS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire kps_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output kps_pkg::t_out      o_out_data
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [56:0] SQ_ONE = 57'h100_0000_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_LAST_RD, S_LAST_CAP, S_K0_RD, S_K0_CAP,
        S_FSET, S_FDIV, S_BLD_M, S_BLD_A, S_DOT_M, S_DOT_A, S_DSIGN, S_DD_M,
        S_DD_A, S_SQRT, S_VEC, S_P1_M, S_P1_A, S_SIN0, S_SIN1, S_FN_M0, S_FN_M1,
        S_FN_A, S_FN_DIV, S_OUT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_i;
    logic [31:0]        r_t;
    kps_pkg::t_key      r_k0;
    kps_pkg::t_key      r_k1;
    logic [16:0]        r_f;
    logic [3:0]         r_k;
    logic signed [33:0] r_d;
    logic               r_neg;
    logic [56:0]        r_sqv;
    logic [56:0]        r_sqres;
    logic [56:0]        r_sqbit;
    logic signed [35:0] r_cx;
    logic signed [35:0] r_cy;
    logic signed [35:0] r_cz;
    logic [4:0]         r_ci;
    logic [28:0]        r_s;
    logic [31:0]        r_th;
    logic [31:0]        r_p1;
    logic signed [35:0] r_s0;
    logic signed [35:0] r_s1;
    logic signed [63:0] r_acc;
    logic               r_fneg;
    logic signed [63:0] r_prod;
    logic [31:0]        r_lin [6];
    logic [15:0]        r_rot [4];
    logic               r_ovalid;
    kps_pkg::t_out      r_odata;

    logic               w_accept;
    logic               w_we;
    kps_pkg::t_key      w_wdata;
    kps_pkg::t_key      w_rdata;
    logic [AW-1:0]      w_raddr;
    logic [CW-1:0]      w_inext;
    logic [1:0]         w_ridx;
    logic signed [15:0] w_ra;
    logic signed [15:0] w_rb;
    logic signed [16:0] w_rb17;
    logic signed [16:0] w_zq;
    logic signed [33:0] w_ba;
    logic signed [33:0] w_bb;
    logic signed [33:0] w_bdiff;
    logic signed [63:0] w_bsum;
    logic signed [33:0] w_ma;
    logic signed [29:0] w_mb;
    logic signed [33:0] w_dabs;
    logic signed [32:0] w_num;
    logic signed [32:0] w_den;
    logic [31:0]        w_an;
    logic [31:0]        w_ad;
    logic               w_fpos;
    logic [57:0]        w_sqtry;
    logic [56:0]        w_sqres;
    logic               w_up;
    logic signed [35:0] w_xs;
    logic signed [35:0] w_ys;
    logic signed [35:0] w_at;
    logic signed [35:0] n_cx;
    logic signed [35:0] n_cy;
    logic signed [35:0] n_cz;
    logic [31:0]        w_p1;
    logic signed [63:0] w_fn;
    logic [63:0]        w_fmag;
    logic signed [50:0] w_q;
    logic signed [50:0] w_qs;
    kps_pkg::t_div_req  w_dreq;
    kps_pkg::t_div_rsp  w_drsp;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    // append port of the key table
    assign w_we = w_accept && (i_in_data.action == kps_pkg::ACT_APPEND)
                  && (r_count < CW'(MAX_KEYS));
    always_comb begin
        w_wdata.time_req = i_in_data.time_req;
        w_wdata.pos_x    = i_in_data.pos_x;
        w_wdata.pos_y    = i_in_data.pos_y;
        w_wdata.pos_z    = i_in_data.pos_z;
        w_wdata.rot_w    = i_in_data.rot_w;
        w_wdata.rot_x    = i_in_data.rot_x;
        w_wdata.rot_y    = i_in_data.rot_y;
        w_wdata.rot_z    = i_in_data.rot_z;
        w_wdata.scale_x  = i_in_data.scale_x;
        w_wdata.scale_y  = i_in_data.scale_y;
        w_wdata.scale_z  = i_in_data.scale_z;
    end

    // read address per state
    assign w_inext = CW'(r_i) + CW'(1);
    always_comb begin
        unique case (r_state)
            S_SCAN_RD: w_raddr = AW'(w_inext);
            S_LAST_RD: w_raddr = AW'(r_count - CW'(1));
            default:   w_raddr = r_i;
        endcase
    end

    kps_ram #(
        .WIDTH ($bits(kps_pkg::t_key)),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // blend operands: linear fields first, quaternion components after
    assign w_ridx  = (r_k >= 4'd6) ? 2'(r_k - 4'd6) : r_k[1:0];
    assign w_ra    = kps_pkg::key_rot(r_k0, w_ridx);
    assign w_rb    = kps_pkg::key_rot(r_k1, w_ridx);
    assign w_rb17  = 17'(w_rb);
    assign w_zq    = r_neg ? -w_rb17 : w_rb17;
    assign w_ba    = (r_k < 4'd6) ? 34'(kps_pkg::key_lin(r_k0, r_k[2:0])) : 34'(w_ra);
    assign w_bb    = (r_k < 4'd6) ? 34'(kps_pkg::key_lin(r_k1, r_k[2:0])) : 34'(w_zq);
    assign w_bdiff = w_bb - w_ba;
    assign w_bsum  = 64'(w_ba) + ((r_prod + 64'sd32768) >>> 16);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_BLD_M: begin
                w_ma = w_bdiff;
                w_mb = $signed({13'b0, r_f});
            end
            S_DOT_M: begin
                w_ma = 34'(w_ra);
                w_mb = 30'(w_rb);
            end
            S_DD_M: begin
                w_ma = r_d;
                w_mb = r_d[29:0];
            end
            S_P1_M: begin
                w_ma = $signed({2'b0, r_th});
                w_mb = $signed({13'b0, r_f});
            end
            S_FN_M0: begin
                w_ma = r_s0[33:0];
                w_mb = 30'(w_ra);
            end
            S_FN_M1: begin
                w_ma = r_s1[33:0];
                w_mb = 30'(w_zq);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // factor setup
    assign w_dabs = r_d[33] ? -r_d : r_d;
    assign w_num  = $signed({1'b0, r_t}) - $signed({1'b0, r_k0.time_req});
    assign w_den  = $signed({1'b0, r_k1.time_req}) - $signed({1'b0, r_k0.time_req});
    assign w_an   = w_num[32] ? 32'(-w_num) : w_num[31:0];
    assign w_ad   = w_den[32] ? 32'(-w_den) : w_den[31:0];
    assign w_fpos = (w_den != '0) && (w_num != '0) && (w_num[32] == w_den[32]);

    // square root step
    assign w_sqtry = {1'b0, r_sqres} + {1'b0, r_sqbit};
    assign w_sqres = ({1'b0, r_sqv} >= w_sqtry) ? ((r_sqres >> 1) + r_sqbit)
                                                : (r_sqres >> 1);

    // CORDIC step, vectoring or rotation
    assign w_up = (r_state == S_VEC) ? (r_cy > 36'sd0) : r_cz[35];
    assign w_xs = r_cx >>> r_ci;
    assign w_ys = r_cy >>> r_ci;
    assign w_at = $signed({4'b0, kps_pkg::atan_q30(r_ci)});
    assign n_cx = w_up ? (r_cx + w_ys) : (r_cx - w_ys);
    assign n_cy = w_up ? (r_cy - w_xs) : (r_cy + w_xs);
    assign n_cz = w_up ? (r_cz + w_at) : (r_cz - w_at);
    assign w_p1 = r_prod[47:16];

    // final weighted sum and rounded quotient
    assign w_fn   = r_acc + r_prod;
    assign w_fmag = w_fn[63] ? 64'(-w_fn) : 64'(w_fn);
    assign w_q    = $signed({1'b0, w_drsp.quo});
    assign w_qs   = r_fneg ? -w_q : w_q;

    always_comb begin
        w_dreq.start = 1'b0;
        w_dreq.num   = '0;
        w_dreq.den   = '0;
        if (r_state == S_FSET) begin
            w_dreq.start = w_fpos && (w_an < w_ad);
            w_dreq.num   = kps_pkg::DIV_NW'({w_an, 16'b0});
            w_dreq.den   = w_ad;
        end else if (r_state == S_FN_A) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = kps_pkg::DIV_NW'(w_fmag + 64'({r_s, 1'b0}));
            w_dreq.den   = kps_pkg::DIV_DW'({r_s, 2'b00});
        end
    end

    kps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_prod <= 64'(w_ma * w_mb);
            if (r_ovalid && !i_out_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_in_data.action)
                            kps_pkg::ACT_CLEAR: r_count <= '0;
                            kps_pkg::ACT_APPEND: begin
                                if (w_we) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            kps_pkg::ACT_SAMPLE: begin
                                r_t <= i_in_data.time_req;
                                r_i <= '0;
                                if (r_count == '0) begin
                                    for (int k = 0; k < 3; k++) begin
                                        r_lin[k]     <= '0;
                                        r_lin[k + 3] <= kps_pkg::ONE_Q16;
                                    end
                                    r_rot[0] <= kps_pkg::ONE_Q14;
                                    r_rot[1] <= '0;
                                    r_rot[2] <= '0;
                                    r_rot[3] <= '0;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    r_state <= (w_inext >= r_count) ? S_LAST_RD : S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (r_t < w_rdata.time_req) begin
                        r_k1    <= w_rdata;
                        r_state <= S_K0_RD;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_LAST_RD: r_state <= S_LAST_CAP;
                S_LAST_CAP: begin
                    for (int k = 0; k < 6; k++) begin
                        r_lin[k] <= kps_pkg::key_lin(w_rdata, 3'(k));
                    end
                    for (int k = 0; k < 4; k++) begin
                        r_rot[k] <= kps_pkg::key_rot(w_rdata, 2'(k));
                    end
                    r_state <= S_OUT;
                end
                S_K0_RD: r_state <= S_K0_CAP;
                S_K0_CAP: begin
                    r_k0    <= w_rdata;
                    r_state <= S_FSET;
                end
                S_FSET: begin
                    r_k <= '0;
                    if (w_fpos && (w_an < w_ad)) begin
                        r_state <= S_FDIV;
                    end else begin
                        r_f     <= w_fpos ? 17'(kps_pkg::ONE_Q16) : '0;
                        r_state <= S_BLD_M;
                    end
                end
                S_FDIV: begin
                    if (w_drsp.done) begin
                        r_f     <= w_drsp.quo[16:0];
                        r_state <= S_BLD_M;
                    end
                end
                S_BLD_M: r_state <= S_BLD_A;
                S_BLD_A: begin
                    if (r_k < 4'd6) begin
                        r_lin[r_k[2:0]] <= w_bsum[31:0];
                    end else begin
                        r_rot[w_ridx] <= kps_pkg::clamp16(w_bsum);
                    end
                    if (r_k == 4'd5) begin
                        r_k     <= '0;
                        r_d     <= '0;
                        r_neg   <= 1'b0;
                        r_state <= S_DOT_M;
                    end else if (r_k == 4'd9) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_BLD_M;
                    end
                end
                S_DOT_M: r_state <= S_DOT_A;
                S_DOT_A: begin
                    r_d <= r_d + $signed(r_prod[33:0]);
                    if (r_k == 4'd3) begin
                        r_state <= S_DSIGN;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_DOT_M;
                    end
                end
                S_DSIGN: begin
                    r_neg <= r_d[33];
                    r_d   <= w_dabs;
                    if ($unsigned(w_dabs) > kps_pkg::NEAR_LIMIT) begin
                        r_k     <= 4'd6;
                        r_state <= S_BLD_M;
                    end else begin
                        r_state <= S_DD_M;
                    end
                end
                S_DD_M: r_state <= S_DD_A;
                S_DD_A: begin
                    r_sqv   <= SQ_ONE - r_prod[56:0];
                    r_sqres <= '0;
                    r_sqbit <= SQ_ONE;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if ({1'b0, r_sqv} >= w_sqtry) begin
                        r_sqv <= r_sqv - w_sqtry[56:0];
                    end
                    r_sqres <= w_sqres;
                    r_sqbit <= r_sqbit >> 2;
                    if (r_sqbit[0]) begin
                        r_s     <= w_sqres[28:0];
                        r_cx    <= 36'(r_d);
                        r_cy    <= $signed({7'b0, w_sqres[28:0]});
                        r_cz    <= '0;
                        r_ci    <= '0;
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    r_ci <= r_ci + 5'd1;
                    if (r_ci == 5'(kps_pkg::CORDIC_STEPS - 1)) begin
                        r_th    <= n_cz[35] ? '0 : n_cz[31:0];
                        r_state <= S_P1_M;
                    end
                end
                S_P1_M: r_state <= S_P1_A;
                S_P1_A: begin
                    r_p1    <= w_p1;
                    r_cx    <= $signed(kps_pkg::CORDIC_KINV);
                    r_cy    <= '0;
                    r_cz    <= $signed({4'b0, r_th}) - $signed({4'b0, w_p1});
                    r_ci    <= '0;
                    r_state <= S_SIN0;
                end
                S_SIN0: begin
                    if (r_ci == 5'(kps_pkg::CORDIC_STEPS - 1)) begin
                        r_s0    <= n_cy;
                        r_cx    <= $signed(kps_pkg::CORDIC_KINV);
                        r_cy    <= '0;
                        r_cz    <= $signed({4'b0, r_p1});
                        r_ci    <= '0;
                        r_state <= S_SIN1;
                    end else begin
                        r_cx <= n_cx;
                        r_cy <= n_cy;
                        r_cz <= n_cz;
                        r_ci <= r_ci + 5'd1;
                    end
                end
                S_SIN1: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    r_ci <= r_ci + 5'd1;
                    if (r_ci == 5'(kps_pkg::CORDIC_STEPS - 1)) begin
                        r_s1    <= n_cy;
                        r_k     <= '0;
                        r_state <= S_FN_M0;
                    end
                end
                S_FN_M0: r_state <= S_FN_M1;
                S_FN_M1: begin
                    r_acc   <= r_prod;
                    r_state <= S_FN_A;
                end
                S_FN_A: begin
                    r_fneg  <= w_fn[63];
                    r_state <= S_FN_DIV;
                end
                S_FN_DIV: begin
                    if (w_drsp.done) begin
                        r_rot[r_k[1:0]] <= kps_pkg::clamp16(64'(w_qs));
                        if (r_k == 4'd3) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= S_FN_M0;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_odata.out_pos_x   <= r_lin[0];
                        r_odata.out_pos_y   <= r_lin[1];
                        r_odata.out_pos_z   <= r_lin[2];
                        r_odata.out_scale_x <= r_lin[3];
                        r_odata.out_scale_y <= r_lin[4];
                        r_odata.out_scale_z <= r_lin[5];
                        r_odata.out_rot_w   <= r_rot[0];
                        r_odata.out_rot_x   <= r_rot[1];
                        r_odata.out_rot_y   <= r_rot[2];
                        r_odata.out_rot_z   <= r_rot[3];
                        r_ovalid            <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
